/* design/bmh_pkg.sv */
// Types and constants shared by the binary min-heap design.
`timescale 1ns / 1ps
package bmh_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned DATA_W  = 32;
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] minimum;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] largest;
    logic signed [DATA_W-1:0] total;
    logic                     is_empty;
    logic                     overflow;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_PL_W,
    S_DN,
    S_DN_RL,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

/* design/bmh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/binary_min_heap_with_stats_core.sv */
// Binary min-heap top level: request handshake, sift sequencer and statistics.
// A push sifts up one level at a time and a pop sifts down one level at a time;
// a dropped push or an empty pop goes straight to the result. The heap RAM has
// a single read port, so a sift-down level reads both children from it one
// after the other. One request is in flight at a time; a result waits in the
// output register while the next request is taken. Heap contents need no
// clearing after reset.
`timescale 1ns / 1ps
module binary_min_heap_with_stats_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bmh_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bmh_pkg::out_req_t out_data
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = AW + 2;
  localparam int unsigned CNTX = (CW > bmh_pkg::COUNT_W) ? CW : bmh_pkg::COUNT_W;

  bmh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic signed [bmh_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [bmh_pkg::DATA_W-1:0] sum_r, sum_nxt;
  logic signed [bmh_pkg::DATA_W-1:0] root_r, root_nxt;
  logic signed [bmh_pkg::DATA_W-1:0] x_r, x_nxt;
  logic signed [bmh_pkg::DATA_W-1:0] left_r, left_nxt;
  logic [AW-1:0]   hole_r, hole_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  bmh_pkg::out_req_t out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [bmh_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [bmh_pkg::DATA_W-1:0] ram_rdata;
  logic signed [bmh_pkg::DATA_W-1:0] rd_val;

  logic [IW-1:0]   l_idx, r_idx, n_ext;
  logic            l_in, r_in;
  logic [AW-1:0]   parent_idx;
  logic [CW-1:0]   last_idx;
  logic [CNTX-1:0] cnt_ext;
  logic [IW-1:0]   best_idx;
  logic signed [bmh_pkg::DATA_W-1:0] best_val;
  logic            in_acc;

  bmh_ram #(
    .WIDTH(bmh_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val     = $signed(ram_rdata);
  assign l_idx      = {1'b0, hole_r, 1'b1};
  assign r_idx      = l_idx + IW'(1);
  assign n_ext      = IW'(count_r);
  assign l_in       = l_idx < n_ext;
  assign r_in       = r_idx < n_ext;
  assign parent_idx = (hole_r - AW'(1)) >> 1;
  assign last_idx   = count_r - CW'(1);
  assign in_acc     = in_valid && in_ready;

  always_comb begin
    best_idx = {2'b00, hole_r};
    best_val = x_r;
    if (left_r < x_r) begin
      best_idx = l_idx;
      best_val = left_r;
    end
    if (r_in && (rd_val < best_val)) begin
      best_idx = r_idx;
      best_val = rd_val;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    root_nxt      = root_r;
    x_nxt         = x_r;
    left_nxt      = left_r;
    hole_nxt      = hole_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = hole_r;
    ram_wdata     = x_r;
    ram_raddr     = l_idx[AW-1:0];
    in_ready      = 1'b0;
    cnt_ext       = CNTX'(count_r);
    unique case (state_r)
      bmh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ovf_nxt   = 1'b0;
          state_nxt = bmh_pkg::S_DONE;
          if (in_data.operation == bmh_pkg::OP_PUSH) begin
            if (count_r >= CW'(CAPACITY)) begin
              ovf_nxt = 1'b1;
            end else begin
              x_nxt     = in_data.value;
              hole_nxt  = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              sum_nxt   = sum_r + in_data.value;
              if (max_r < in_data.value) begin
                max_nxt = in_data.value;
              end
              state_nxt = bmh_pkg::S_UP;
            end
          end else if (count_r != '0) begin
            count_nxt = last_idx;
            sum_nxt   = sum_r - root_r;
            if (last_idx == '0) begin
              max_nxt = bmh_pkg::INT_MIN;
            end else begin
              ram_raddr = last_idx[AW-1:0];
              state_nxt = bmh_pkg::S_PL_W;
            end
          end
        end
      end
      bmh_pkg::S_UP: begin
        if (hole_r == '0) begin
          ram_we    = 1'b1;
          root_nxt  = x_r;
          state_nxt = bmh_pkg::S_DONE;
        end else begin
          ram_raddr = parent_idx;
          state_nxt = bmh_pkg::S_UP_CMP;
        end
      end
      bmh_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        if (x_r < rd_val) begin
          ram_wdata = rd_val;
          hole_nxt  = parent_idx;
          state_nxt = bmh_pkg::S_UP;
        end else begin
          state_nxt = bmh_pkg::S_DONE;
        end
      end
      bmh_pkg::S_PL_W: begin
        x_nxt     = rd_val;
        hole_nxt  = '0;
        state_nxt = bmh_pkg::S_DN;
      end
      bmh_pkg::S_DN: begin
        if (l_in) begin
          ram_raddr = l_idx[AW-1:0];
          state_nxt = bmh_pkg::S_DN_RL;
        end else begin
          ram_we    = 1'b1;
          if (hole_r == '0) begin
            root_nxt = x_r;
          end
          state_nxt = bmh_pkg::S_DONE;
        end
      end
      bmh_pkg::S_DN_RL: begin
        left_nxt  = rd_val;
        ram_raddr = r_idx[AW-1:0];
        state_nxt = bmh_pkg::S_DN_CMP;
      end
      bmh_pkg::S_DN_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = best_val;
        if (hole_r == '0) begin
          root_nxt = best_val;
        end
        if (best_idx == {2'b00, hole_r}) begin
          state_nxt = bmh_pkg::S_DONE;
        end else begin
          hole_nxt  = best_idx[AW-1:0];
          state_nxt = bmh_pkg::S_DN;
        end
      end
      bmh_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.minimum  = (count_r == '0) ? '0 : root_r;
          out_nxt.count    = cnt_ext[bmh_pkg::COUNT_W-1:0];
          out_nxt.largest  = max_r;
          out_nxt.total    = sum_r;
          out_nxt.is_empty = (count_r == '0);
          out_nxt.overflow = ovf_r;
          state_nxt        = bmh_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmh_pkg::S_IDLE;
      count_r     <= '0;
      max_r       <= bmh_pkg::INT_MIN;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    x_r    <= x_nxt;
    left_r <= left_nxt;
    hole_r <= hole_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) < count_r))
    else $error("heap write beyond held elements");

  a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmh_pkg::S_IDLE && count_r == '0) |-> (max_r == bmh_pkg::INT_MIN))
    else $error("running max not reset on empty heap");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmh_pkg::S_DONE && ovf_r) |-> (count_r == CW'(CAPACITY)))
    else $error("overflow flagged on non-full heap");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in flight");
`endif

endmodule
